// ===== rtl/rtpal_pkg.sv =====
// Shared types, constants and helper functions for the RTP A-law depacketizer.
package rtpal_pkg;

   // Default longest datagram in bytes
   localparam int MAX_PACKET_BYTES_DEF = 65536;

   // Header parsing
   localparam logic [16:0] HEADER_BYTES = 17'd12;
   localparam logic [16:0] START_LIMIT  = 17'h1ffff;
   localparam logic [1:0]  RTP_VERSION  = 2'd2;

   // Decoupling queue between the parser and the sample path
   localparam int QUEUE_DEPTH = 4;

   // Volume register
   localparam logic [6:0] VOLUME_RESET = 7'd100;
   localparam logic [6:0] VOLUME_MAX   = 7'd100;

   // A-law expansion constants
   localparam logic [7:0] ALAW_XOR   = 8'h55;
   localparam logic [8:0] SEG_BIAS   = 9'h108;
   localparam logic [8:0] SEG0_BIAS  = 9'd8;

   // x/100 as (x*DIV100_MUL) >> DIV100_SHIFT, exact for x below 2^22
   localparam logic [22:0] DIV100_MUL   = 23'd5368710;
   localparam int          DIV100_SHIFT = 29;

   // peak*100/32767 as (peak*LEVEL_MUL) >> LEVEL_SHIFT
   localparam logic [21:0] LEVEL_MUL   = 22'd3276900;
   localparam int          LEVEL_SHIFT = 30;
   localparam logic [14:0] PEAK_FULL   = 15'd32767;
   localparam logic [6:0]  LEVEL_MAX   = 7'd100;

   // One decoded sample waiting for scaling
   typedef struct packed {
      logic [14:0] mag;
      logic        neg;
      logic        last;
   } sample_type;

   // Write side of the queue
   typedef struct packed {
      logic       valid;
      sample_type data;
   } push_type;

   // G.711 A-law expansion into magnitude and sign
   function automatic sample_type alaw_expand(input logic [7:0] code, input logic last);
      logic [7:0]  v;
      logic [2:0]  seg;
      logic [8:0]  base;
      logic [14:0] mag;
      sample_type  s;
      v    = code ^ ALAW_XOR;
      seg  = v[6:4];
      base = {1'b0, v[3:0], 4'b0000} + ((seg != 3'd0) ? SEG_BIAS : SEG0_BIAS);
      mag  = 15'(base);
      if (seg > 3'd1) begin
         mag = mag << (seg - 3'd1);
      end
      s.mag  = mag;
      s.neg  = ~v[7];
      s.last = last;
      return s;
   endfunction

   // Peak magnitude in percent of full scale, capped
   function automatic logic [6:0] level_of(input logic [14:0] peak);
      logic [36:0] prod;
      logic [6:0]  lvl;
      prod = 37'(peak) * 37'(LEVEL_MUL);
      lvl  = prod[36:LEVEL_SHIFT];
      if (peak == PEAK_FULL) begin
         lvl = LEVEL_MAX;
      end
      if (lvl > LEVEL_MAX) begin
         lvl = LEVEL_MAX;
      end
      return lvl;
   endfunction

endpackage

// ===== rtl/rtp_alaw_depacketizer_with_levels.sv =====
// Top level of the RTP A-law depacketizer with peak level reporting.
//
// Usage: datagram bytes enter one word per cycle on the req_ channel, with
// req_tlast on the final byte. Header bytes (fixed header, CSRC list and
// extension) and every byte of a dropped packet cause no result. Each payload
// byte gives one rsp_ word: the A-law sample scaled by the csr_ volume in
// percent. On the word made from the last byte, rsp_tlast is high and the two
// level fields carry the packet's peak raw and scaled levels in percent.
// Throughput: one byte per cycle, both header and payload, while req_tready is high.
// A payload byte accepted at one edge is written to the queue at that same edge
// and then passes the product, divide by 100, peak/sign stage and output
// registers on its way to rsp_tvalid.
// A four-deep queue sits between the header parser and the scaling pipeline;
// when the receiver stalls the pipeline holds, the queue fills and req_tready
// drops once it is full. Bytes keep being accepted while a result waits.
// Reset: synchronous; clears the parser, queue, pipeline and peaks, and sets
// the volume to 100.
module rtp_alaw_depacketizer_with_levels #(
   parameter int MAX_PACKET_BYTES = rtpal_pkg::MAX_PACKET_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] packet_byte
   input  logic        req_tlast,   // last_byte
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] pcm_sample, [22:16] input_level,
                                    // [29:23] output_level, [31:30] zero
   output logic        rsp_tlast,   // packet_end
   // Volume register
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data  // playback_volume
);

   rtpal_pkg::push_type   push;
   rtpal_pkg::sample_type head;
   logic                  q_full;
   logic                  head_valid;
   logic                  pop;

   rtpal_front #(
      .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .push       (push)
   );

   rtpal_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   rtpal_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   // Levels only travel on the last word of a packet
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tdata[29:16] == 14'd0))
      else $error("level fields nonzero on a word that does not end a packet");

   // Levels never exceed full scale
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[22:16] <= 7'd100 && rsp_tdata[29:23] <= 7'd100))
      else $error("level above 100 percent");

   // Volume is at most unity, so the scaled level never passes the raw level
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[29:23] <= rsp_tdata[22:16]))
      else $error("output level above input level");

   // The parser never writes into a full queue
   assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !q_full)
      else $error("queue overrun");

endmodule

// ===== rtl/rtpal_front.sv =====
// Front end: RTP header parser that classifies each byte and expands payload bytes.
module rtpal_front #(
   parameter int MAX_PACKET_BYTES = rtpal_pkg::MAX_PACKET_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 req_tlast,
   input  logic                 q_full,
   output rtpal_pkg::push_type  push
);

   localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [16:0]      start_ff, start_in;
   logic             bad_ff, bad_in;
   logic             ext_ff, ext_in;
   logic [7:0]       ext_hi_ff, ext_hi_in;

   logic        accept;
   logic [16:0] pos_wide;
   logic [17:0] ext_cnt_hi_pos;
   logic [17:0] ext_cnt_lo_pos;
   logic [15:0] ext_words;
   logic [18:0] ext_start;
   logic [16:0] ext_start_sat;
   logic        ext_too_far;
   logic        emit;

   assign req_tready = ~q_full;
   assign accept     = req_tvalid & req_tready;

   // Extension header arithmetic
   assign pos_wide       = 17'(pos_ff);
   assign ext_cnt_hi_pos = 18'(start_ff) + 18'd2;
   assign ext_cnt_lo_pos = 18'(start_ff) + 18'd3;
   assign ext_words      = {ext_hi_ff, req_tdata};
   assign ext_start      = 19'(start_ff) + 19'd4 + {1'b0, ext_words, 2'b00};
   assign ext_start_sat  = (ext_start > 19'(rtpal_pkg::START_LIMIT)) ?
                           rtpal_pkg::START_LIMIT : ext_start[16:0];
   assign ext_too_far    = 19'(ext_start_sat) >= 19'(MAX_PACKET_BYTES);

   // Header state update and payload decision
   always_comb begin
      start_in  = start_ff;
      bad_in    = bad_ff;
      ext_in    = ext_ff;
      ext_hi_in = ext_hi_ff;
      if (pos_ff == '0) begin
         bad_in   = bad_ff | (req_tdata[7:6] != rtpal_pkg::RTP_VERSION);
         start_in = rtpal_pkg::HEADER_BYTES + 17'({req_tdata[3:0], 2'b00});
         ext_in   = req_tdata[4];
      end else if (ext_ff) begin
         if (18'(pos_wide) == ext_cnt_hi_pos) begin
            ext_hi_in = req_tdata;
         end else if (18'(pos_wide) == ext_cnt_lo_pos) begin
            start_in = ext_start_sat;
            ext_in   = 1'b0;
            if (ext_too_far) begin
               bad_in = 1'b1;
            end
         end
      end
      emit = (pos_ff != '0) && !bad_in && !ext_in && (pos_wide >= start_in);
   end

   // Next position: cleared after the last byte, saturating otherwise
   always_comb begin
      pos_in = pos_ff;
      if (req_tlast) begin
         pos_in = '0;
      end else if (pos_ff < POS_W'(MAX_PACKET_BYTES)) begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   // Payload words go to the queue
   assign push.valid = accept & emit;
   assign push.data  = rtpal_pkg::alaw_expand(req_tdata, req_tlast);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         start_ff  <= rtpal_pkg::HEADER_BYTES;
         bad_ff    <= 1'b0;
         ext_ff    <= 1'b0;
         ext_hi_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         if (req_tlast) begin
            start_ff  <= rtpal_pkg::HEADER_BYTES;
            bad_ff    <= 1'b0;
            ext_ff    <= 1'b0;
            ext_hi_ff <= '0;
         end else begin
            start_ff  <= start_in;
            bad_ff    <= bad_in;
            ext_ff    <= ext_in;
            ext_hi_ff <= ext_hi_in;
         end
      end
   end

endmodule

// ===== rtl/rtpal_queue.sv =====
// Short queue of decoded samples between the parser and the scaling pipeline.
module rtpal_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  rtpal_pkg::push_type    push,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output rtpal_pkg::sample_type  head
);

   localparam int DEPTH = rtpal_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rtpal_pkg::sample_type entry_ff [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid & ~full;
   assign do_pop     = pop & head_valid;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.data;
      end
   end

endmodule

// ===== rtl/rtpal_back.sv =====
// Back end: volume scaling, peak tracking, level computation and output register.
module rtpal_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  rtpal_pkg::sample_type  head,
   output logic                   pop,
   input  logic                   csr_wr_en,
   input  logic [6:0]             csr_wr_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,
   output logic                   rsp_tlast
);

   logic [6:0] vol_ff;
   logic [6:0] vol_eff;
   logic       adv;

   // Stage 1: magnitude times volume
   logic        a_valid_ff;
   logic [21:0] a_prod_ff;
   logic [14:0] a_mag_ff;
   logic        a_neg_ff, a_last_ff;

   // Stage 2: divide by 100
   logic        b_valid_ff;
   logic [44:0] b_recip;
   logic [14:0] b_quot_ff;
   logic [14:0] b_mag_ff;
   logic        b_neg_ff, b_last_ff;

   // Stage 3: sign and peaks
   logic        c_valid_ff;
   logic [15:0] c_sample_ff;
   logic        c_last_ff;
   logic [14:0] c_peak_raw_ff, c_peak_scl_ff;
   logic [14:0] peak_raw_ff, peak_scl_ff;
   logic [14:0] peak_raw_in, peak_scl_in;

   // Output register
   logic        rsp_valid_ff;
   logic [15:0] rsp_sample_ff;
   logic        rsp_last_ff;
   logic [6:0]  rsp_in_lvl_ff, rsp_out_lvl_ff;

   // Whole pipeline moves when the output slot is free or being taken
   assign adv = ~rsp_valid_ff | rsp_tready;
   assign pop = adv & head_valid;

   assign vol_eff = (vol_ff > rtpal_pkg::VOLUME_MAX) ? rtpal_pkg::VOLUME_MAX : vol_ff;

   // Volume register
   always_ff @(posedge clock) begin
      if (reset) begin
         vol_ff <= rtpal_pkg::VOLUME_RESET;
      end else if (csr_wr_en) begin
         vol_ff <= csr_wr_data;
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff   <= head_valid;
         b_valid_ff   <= a_valid_ff;
         c_valid_ff   <= b_valid_ff;
         rsp_valid_ff <= c_valid_ff;
      end
   end

   // Stage 1
   always_ff @(posedge clock) begin
      if (adv) begin
         a_prod_ff <= 22'(head.mag) * 22'(vol_eff);
         a_mag_ff  <= head.mag;
         a_neg_ff  <= head.neg;
         a_last_ff <= head.last;
      end
   end

   // Stage 2: reciprocal multiply, exact over the product range
   assign b_recip = 45'(a_prod_ff) * 45'(rtpal_pkg::DIV100_MUL);

   always_ff @(posedge clock) begin
      if (adv) begin
         b_quot_ff <= b_recip[rtpal_pkg::DIV100_SHIFT +: 15];
         b_mag_ff  <= a_mag_ff;
         b_neg_ff  <= a_neg_ff;
         b_last_ff <= a_last_ff;
      end
   end

   // Stage 3: running peaks include the current sample
   assign peak_raw_in = (b_mag_ff  > peak_raw_ff) ? b_mag_ff  : peak_raw_ff;
   assign peak_scl_in = (b_quot_ff > peak_scl_ff) ? b_quot_ff : peak_scl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_raw_ff <= '0;
         peak_scl_ff <= '0;
      end else if (adv && b_valid_ff) begin
         peak_raw_ff <= b_last_ff ? '0 : peak_raw_in;
         peak_scl_ff <= b_last_ff ? '0 : peak_scl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_sample_ff   <= b_neg_ff ? (16'd0 - {1'b0, b_quot_ff}) : {1'b0, b_quot_ff};
         c_last_ff     <= b_last_ff;
         c_peak_raw_ff <= peak_raw_in;
         c_peak_scl_ff <= peak_scl_in;
      end
   end

   // Output register with levels on the last word
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_sample_ff  <= c_sample_ff;
         rsp_last_ff    <= c_last_ff;
         rsp_in_lvl_ff  <= c_last_ff ? rtpal_pkg::level_of(c_peak_raw_ff) : '0;
         rsp_out_lvl_ff <= c_last_ff ? rtpal_pkg::level_of(c_peak_scl_ff) : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_out_lvl_ff, rsp_in_lvl_ff, rsp_sample_ff};

endmodule

// ===== tb/sv/rtp_alaw_depacketizer_with_levels_test.sv =====
// Self-checking stream testbench for the RTP A-law depacketizer with peak levels.
module rtp_alaw_depacketizer_with_levels_test;

   timeunit 1ns;
   timeprecision 1ps;

   // Short packet limit so the counter and start saturation are reached cheaply
   localparam int MAX_BYTES  = 256;
   localparam int TAIL_WAIT  = 20;
   localparam int PHASE_SIZE = 60;

   // One datagram byte as it travels on req_
   typedef struct packed {
      logic       last;
      logic [7:0] data;
   } dgram_byte_type;

   // One expected sample word
   typedef struct packed {
      logic [15:0] pcm;
      logic        fin;
      logic [6:0]  in_lvl;
      logic [6:0]  out_lvl;
   } pcm_word_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'h00;   // [7:0] packet_byte
   logic        req_tlast   = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [31:0] rsp_tdata;             // [15:0] pcm, [22:16] in level, [29:23] out level
   logic        rsp_tlast;             // packet_end
   logic        csr_wr_en   = 1'b0;
   logic [6:0]  csr_wr_data = 7'd0;    // playback_volume

   dgram_byte_type byte_q[$];     // words waiting for the driver
   logic [7:0]     pkt_q[$];      // packet under construction
   pcm_word_type   pcm_expect[$]; // samples still to come out
   int             error_count = 0;

   // Predictor state
   logic [6:0]  volume      = rtpal_pkg::VOLUME_RESET;
   int          byte_pos    = 0;
   int          pay_start   = int'(rtpal_pkg::HEADER_BYTES);
   logic        pkt_bad     = 1'b0;
   logic        ext_pending = 1'b0;
   logic [7:0]  ext_hi      = 8'h00;
   int          peak_raw    = 0;
   int          peak_scaled = 0;

   // Driver and receiver pacing
   int             burst_left  = 1;
   int             gap_left    = 0;
   int             stall_cycle = 0;
   int             hold_left   = 0;
   dgram_byte_type next_word;
   pcm_word_type   want;

   rtp_alaw_depacketizer_with_levels #(
      .MAX_PACKET_BYTES(MAX_BYTES)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Signed linear value of an A-law code
   function automatic int alaw_value(input logic [7:0] code);
      logic [7:0] t;
      int         seg;
      int         m;
      t   = code ^ rtpal_pkg::ALAW_XOR;
      seg = int'(t[6:4]);
      m   = int'(t[3:0]) * 16 + 8;
      if (seg != 0) begin
         m = (m + 256) << (seg - 1);
      end
      return t[7] ? m : -m;
   endfunction

   // Peak in percent of full scale, capped
   function automatic logic [6:0] pct_of(input int peak);
      int l;
      l = peak * 100 / 32767;
      return (l > 100) ? 7'd100 : 7'(l);
   endfunction

   // Parse one accepted byte and queue the sample it yields, if any
   task automatic track_byte(input logic [7:0] b, input logic lst);
      int           p;
      int           s;
      int           vol;
      int           raw;
      int           scaled;
      pcm_word_type w;
      p = byte_pos;
      if (p == 0) begin
         if (b[7:6] != rtpal_pkg::RTP_VERSION) begin
            pkt_bad = 1'b1;
         end
         pay_start   = int'(rtpal_pkg::HEADER_BYTES) + int'(b[3:0]) * 4;
         ext_pending = b[4];
      end else if (ext_pending) begin
         if (p == pay_start + 2) begin
            ext_hi = b;
         end else if (p == pay_start + 3) begin
            s = pay_start + 4 + int'({ext_hi, b}) * 4;
            if (s > int'(rtpal_pkg::START_LIMIT)) begin
               s = int'(rtpal_pkg::START_LIMIT);
            end
            pay_start   = s;
            ext_pending = 1'b0;
            if (s >= MAX_BYTES) begin
               pkt_bad = 1'b1;
            end
         end
      end
      if (p != 0 && !pkt_bad && !ext_pending && p >= pay_start) begin
         vol    = (volume > rtpal_pkg::VOLUME_MAX) ?
                  int'(rtpal_pkg::VOLUME_MAX) : int'(volume);
         raw    = alaw_value(b);
         scaled = raw * vol / 100;
         if ((raw < 0 ? -raw : raw) > peak_raw) begin
            peak_raw = (raw < 0) ? -raw : raw;
         end
         if ((scaled < 0 ? -scaled : scaled) > peak_scaled) begin
            peak_scaled = (scaled < 0) ? -scaled : scaled;
         end
         w.pcm     = 16'(scaled);
         w.fin     = lst;
         w.in_lvl  = lst ? pct_of(peak_raw) : 7'd0;
         w.out_lvl = lst ? pct_of(peak_scaled) : 7'd0;
         pcm_expect.push_back(w);
      end
      if (lst) begin
         byte_pos    = 0;
         pay_start   = int'(rtpal_pkg::HEADER_BYTES);
         pkt_bad     = 1'b0;
         ext_pending = 1'b0;
         ext_hi      = 8'h00;
         peak_raw    = 0;
         peak_scaled = 0;
      end else if (byte_pos < MAX_BYTES) begin
         byte_pos = byte_pos + 1;
      end
   endtask

   // Fixed header, CSRC list and, with X set, the extension (body capped at 64 bytes)
   task automatic build_header(input logic [7:0] first, input int words);
      pkt_q.push_back(first);
      repeat (11 + 4 * int'(first[3:0])) pkt_q.push_back(8'($urandom));
      if (first[4]) begin
         pkt_q.push_back(8'($urandom));
         pkt_q.push_back(8'($urandom));
         pkt_q.push_back(words[15:8]);
         pkt_q.push_back(words[7:0]);
         repeat ((words < 16) ? words * 4 : 64) pkt_q.push_back(8'($urandom));
      end
   endtask

   task automatic build_payload(input int n);
      repeat (n) pkt_q.push_back(8'($urandom));
   endtask

   // Hand the packet to the driver, cut after keep bytes when keep is set
   task automatic send_packet(input int keep);
      int n;
      n = (keep > 0 && keep < pkt_q.size()) ? keep : pkt_q.size();
      for (int i = 0; i < n; i++) begin
         byte_q.push_back('{i == n - 1, pkt_q[i]});
      end
      pkt_q.delete();
   endtask

   // Mostly well-formed packets, plus bad versions, cut packets and huge extensions
   task automatic queue_random_packets(input int n_bytes);
      int         base;
      int         kind;
      int         cc;
      int         words;
      int         ver;
      logic [7:0] first;
      base = byte_q.size();
      while (byte_q.size() - base < n_bytes) begin
         kind  = $urandom_range(0, 99);
         cc    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 2);
         words = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 70) : $urandom_range(0, 3);
         first = {2'b10, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 9) < 3), 4'(cc)};
         if (kind < 70) begin
            build_header(first, words);
            if ($urandom_range(0, 32) == 0) begin
               build_payload($urandom_range(MAX_BYTES - 20, MAX_BYTES + 20));
            end else begin
               build_payload($urandom_range(1, 40));
            end
            send_packet(0);
         end else if (kind < 80) begin
            ver = $urandom_range(0, 2);
            if (ver == 2) begin
               ver = 3;
            end
            first[7:6] = 2'(ver);
            build_header(first, words);
            build_payload($urandom_range(1, 20));
            send_packet(0);
         end else if (kind < 90) begin
            build_header(first, words);
            send_packet($urandom_range(1, pkt_q.size()));
         end else if (kind < 95) begin
            first[4] = 1'b1;
            build_header(first, $urandom_range(0, 65535));
            build_payload($urandom_range(1, 8));
            send_packet(0);
         end else begin
            build_header(first, words);
            send_packet(0);
         end
      end
   endtask

   // Block until no word is pending or in flight
   task automatic wait_idle;
      while (byte_q.size() != 0 || req_tvalid || pcm_expect.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Volume write once the block has drained
   task automatic write_volume(input logic [6:0] v);
      wait_idle();
      repeat (TAIL_WAIT) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      volume = v;
   endtask

   task automatic note_mismatch(input pcm_word_type exp_w, input logic have_exp);
      error_count++;
      if (error_count <= 10) begin
         if (have_exp) begin
            $display("mismatch: pcm %0d/%0d end %0b/%0b in %0d/%0d out %0d/%0d pad %0b",
                     $signed(exp_w.pcm), $signed(rsp_tdata[15:0]), exp_w.fin, rsp_tlast,
                     exp_w.in_lvl, rsp_tdata[22:16], exp_w.out_lvl, rsp_tdata[29:23],
                     rsp_tdata[31:30]);
         end else begin
            $display("unexpected word: tdata %h tlast %0b", rsp_tdata, rsp_tlast);
         end
      end
   endtask

   // Driver: bursts of random length with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_byte(req_tdata, req_tlast);
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (byte_q.size() > 0) begin
               next_word = byte_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_word.data;
               req_tlast  <= next_word.last;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 48);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left = burst_left - 1;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall pattern steps through always ready, mostly ready, coin-flip and long holds
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         stall_cycle = stall_cycle + 1;
         case ((stall_cycle >> 8) % 4)
            0: begin
               rsp_tready <= 1'b1;
            end
            1: begin
               rsp_tready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
               rsp_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
               if (hold_left > 0) begin
                  hold_left = hold_left - 1;
                  rsp_tready <= 1'b0;
               end else if ($urandom_range(0, 15) == 0) begin
                  hold_left = $urandom_range(1, 12);
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
               end
            end
         endcase
      end
   end

   // Monitor: compare each accepted word with the oldest expected sample
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pcm_expect.size() == 0) begin
            note_mismatch(want, 1'b0);
         end else begin
            want = pcm_expect.pop_front();
            if (rsp_tdata[15:0] !== want.pcm || rsp_tlast !== want.fin
                || rsp_tdata[22:16] !== want.in_lvl || rsp_tdata[29:23] !== want.out_lvl
                || rsp_tdata[31:30] !== 2'b00) begin
               note_mismatch(want, 1'b1);
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin
      logic [6:0] vols[6];
      vols = '{7'd0, 7'd127, 7'd1, 7'd100, 7'd0, 7'd101};
      vols[4] = 7'($urandom_range(2, 98));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // A-law code extremes at the reset volume
      build_header(8'h80, 0);
      pkt_q.push_back(8'h00);
      pkt_q.push_back(8'hFF);
      pkt_q.push_back(8'h55);
      pkt_q.push_back(8'hD5);
      pkt_q.push_back(8'h2A);
      pkt_q.push_back(8'hAA);
      pkt_q.push_back(8'h80);
      pkt_q.push_back(8'h7F);
      send_packet(0);
      // wrong version: dropped whole
      build_header(8'h40, 0);
      build_payload(3);
      send_packet(0);
      // one-byte datagram
      pkt_q.push_back(8'h80);
      send_packet(0);
      // ends inside the CSRC list
      build_header(8'h9F, 0);
      send_packet(20);
      // header only, empty payload
      build_header(8'h80, 0);
      send_packet(0);
      // maximal extension length: start saturates, packet dropped
      build_header(8'h90, 16'hFFFF);
      build_payload(2);
      send_packet(0);
      // CSRC list and a one-word extension ahead of the payload
      build_header(8'hB2, 1);
      build_payload(3);
      send_packet(0);
      // runs past the byte counter limit
      build_header(8'h80, 0);
      build_payload(MAX_BYTES);
      send_packet(0);

      // random phases, one volume setting each
      foreach (vols[i]) begin
         write_volume(vols[i]);
         queue_random_packets(PHASE_SIZE);
      end

      wait_idle();
      repeat (TAIL_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #1_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/rtpal_pkg.sv
rtl/rtpal_front.sv
rtl/rtpal_queue.sv
rtl/rtpal_back.sv
rtl/rtp_alaw_depacketizer_with_levels.sv
tb/sv/rtp_alaw_depacketizer_with_levels_test.sv
